[hdl/mfsgd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsgd_pkg
// Shared widths, command codes, register indexes and controller commands.
// ----------------------------------------------------------------------------
package mfsgd_pkg;

  localparam int NUM_USERS_DEF = 1024;
  localparam int NUM_ITEMS_DEF = 1024;
  localparam int FACTORS_DEF   = 10;

  localparam int IDX_W  = 10;
  localparam int RAT_W  = 11;
  localparam int FIDX_W = 4;
  localparam int VAL_W  = 16;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_TRAIN   = 2'd1;
  localparam logic [1:0] CMD_PREDICT = 2'd2;

  localparam logic [1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [1:0] REG_REGULARIZE = 2'd1;
  localparam logic [1:0] REG_MIN_RATING = 2'd2;
  localparam logic [1:0] REG_MAX_RATING = 2'd3;

  typedef struct packed {
    logic capture;
    logic rd_start;
    logic mac;
    logic fin_dot;
    logic upd_mul;
    logic upd_wr;
    logic load_wr;
    logic out_set;
  } mfsgd_cmd_t;

  typedef struct packed {
    logic last_factor;
    logic rows_ok;
  } mfsgd_stat_t;

endpackage

[hdl/mfsgd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsgd_ctrl
// Controller: sequences load, dot product and per-factor update steps.
// ----------------------------------------------------------------------------
module mfsgd_ctrl
  import mfsgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  output logic        out_valid,
  input  logic        out_stall,
  input  mfsgd_stat_t stat,
  output mfsgd_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_URD  = 3'd4;
  localparam logic [2:0] S_UMUL = 3'd5;
  localparam logic [2:0] S_UWR  = 3'd6;

  logic [2:0] state, state_next;
  logic       is_train, is_train_next;
  logic       out_valid_next;
  logic       accept;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    is_train_next  = is_train;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (command == CMD_TRAIN || command == CMD_PREDICT) begin
            is_train_next = (command == CMD_TRAIN);
            cmd.rd_start  = 1'b1;
            state_next    = S_RD;
          end else begin
            cmd.load_wr    = (command == CMD_LOAD);
            cmd.out_set    = 1'b1;
            out_valid_next = 1'b1;
          end
        end
      end
      S_RD: state_next = S_MAC;
      S_MAC: begin
        cmd.mac = 1'b1;
        if (stat.last_factor) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin_dot = 1'b1;
        if (is_train && stat.rows_ok) begin
          cmd.rd_start = 1'b1;
          state_next   = S_URD;
        end else begin
          cmd.out_set    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_URD: state_next = S_UMUL;
      S_UMUL: begin
        cmd.upd_mul = 1'b1;
        state_next  = S_UWR;
      end
      S_UWR: begin
        cmd.upd_wr = 1'b1;
        if (stat.last_factor) begin
          cmd.out_set    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          state_next = S_URD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      is_train  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      is_train  <= is_train_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !accept) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_busy_no_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> !cmd.out_set) else $error("result during dot product");

endmodule

[hdl/mfsgd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsgd_datapath
// Factor memories, serial dot product, SGD update and result register.
// ----------------------------------------------------------------------------
module mfsgd_datapath
  import mfsgd_pkg::*;
#(
  parameter int NUM_USERS = NUM_USERS_DEF,
  parameter int NUM_ITEMS = NUM_ITEMS_DEF,
  parameter int FACTORS   = FACTORS_DEF
) (
  input  logic                    clk,
  input  mfsgd_cmd_t              cmd,
  output mfsgd_stat_t             stat,
  input  logic [1:0]              command,
  input  logic [IDX_W-1:0]        user,
  input  logic [IDX_W-1:0]        item,
  input  logic [RAT_W-1:0]        rating,
  input  logic                    load_table,
  input  logic [FIDX_W-1:0]       factor_index,
  input  logic signed [VAL_W-1:0] load_value,
  input  logic [15:0]             learn_rate,
  input  logic [15:0]             regularization,
  input  logic [RAT_W-1:0]        min_rating,
  input  logic [RAT_W-1:0]        max_rating,
  output logic signed [VAL_W-1:0] result_value,
  output logic                    clamped
);

  localparam int UDEPTH = NUM_USERS * FACTORS;
  localparam int IDEPTH = NUM_ITEMS * FACTORS;
  localparam int UA_W   = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
  localparam int IA_W   = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
  localparam int F_W    = (FACTORS > 1) ? $clog2(FACTORS) : 1;
  localparam int ACC_W  = 32 + F_W + 1;

  localparam logic signed [ACC_W-15:0] ERR_MAX = (ACC_W-14)'(32767);
  localparam logic signed [ACC_W-15:0] ERR_MIN = (ACC_W-14)'(-32768);
  localparam logic signed [25:0]       NEW_MAX = 26'sd32767;
  localparam logic signed [25:0]       NEW_MIN = -26'sd32768;

  logic signed [VAL_W-1:0] umem [UDEPTH];
  logic signed [VAL_W-1:0] imem [IDEPTH];

  logic [IDX_W-1:0]  user_r, item_r;
  logic [RAT_W-1:0]  rating_r;
  logic [1:0]        cmd_r;
  logic              user_ok, item_ok;
  logic [F_W-1:0]    fcnt, rd_fcnt;
  logic [UA_W-1:0]   ubase, uaddr, uraddr;
  logic [IA_W-1:0]   ibase, iaddr, iraddr;
  logic signed [VAL_W-1:0] u_rd, v_rd, u_new, v_new;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-17:0] pred;
  logic signed [ACC_W-15:0] err;
  logic signed [16:0] su;
  logic signed [32:0] eu_prod, ev_prod, ru_prod, rv_prod;
  logic signed [39:0] gu_c, gv_c, gu_r, gv_r;
  logic signed [56:0] pu, pv;
  logic signed [25:0] nu, nv;
  logic sat_flag;
  logic [UA_W-1:0] luaddr;
  logic [IA_W-1:0] liaddr;
  logic            fidx_ok;
  logic signed [ACC_W-16:0] cl;
  logic signed [ACC_W-16:0] mn, mx;

  assign ubase = UA_W'(user_r) * UA_W'(FACTORS);
  assign ibase = IA_W'(item_r) * IA_W'(FACTORS);
  assign uaddr = ubase + UA_W'(fcnt);
  assign iaddr = ibase + IA_W'(fcnt);
  assign stat.last_factor = (fcnt == F_W'(FACTORS - 1));
  assign stat.rows_ok     = user_ok && item_ok;

  // prefetch the next factor while the dot product runs
  assign rd_fcnt = (cmd.mac && !stat.last_factor) ? F_W'(fcnt + 1'b1) : fcnt;
  assign uraddr  = ubase + UA_W'(rd_fcnt);
  assign iraddr  = ibase + IA_W'(rd_fcnt);

  // load write address
  assign fidx_ok = 32'(factor_index) < FACTORS;
  assign luaddr  = UA_W'(user) * UA_W'(FACTORS) + UA_W'(factor_index);
  assign liaddr  = IA_W'(item) * IA_W'(FACTORS) + IA_W'(factor_index);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && fidx_ok && !load_table && 32'(user) < NUM_USERS)
      umem[luaddr] <= load_value;
    else if (cmd.upd_wr)
      umem[uaddr] <= u_new;
    u_rd <= umem[uraddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && fidx_ok && load_table && 32'(item) < NUM_ITEMS)
      imem[liaddr] <= load_value;
    else if (cmd.upd_wr)
      imem[iaddr] <= v_new;
    v_rd <= imem[iraddr];
  end

  always_comb begin
    pred = (ACC_W-16)'(acc >>> 16);
    err  = (ACC_W-14)'(signed'({1'b0, rating_r})) - (ACC_W-14)'(pred);
  end

  // gradients using the saturated error held in su
  assign ev_prod = 33'(su) * 33'(v_rd);
  assign eu_prod = 33'(su) * 33'(u_rd);
  assign ru_prod = 33'(signed'({1'b0, regularization})) * 33'(u_rd);
  assign rv_prod = 33'(signed'({1'b0, regularization})) * 33'(v_rd);
  assign gu_c    = (40'(ev_prod) <<< 8) - 40'(ru_prod);
  assign gv_c    = (40'(eu_prod) <<< 8) - 40'(rv_prod);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      user_r   <= user;
      item_r   <= item;
      rating_r <= rating;
      cmd_r    <= command;
      user_ok  <= 32'(user) < NUM_USERS;
      item_ok  <= 32'(item) < NUM_ITEMS;
      acc      <= '0;
      sat_flag <= 1'b0;
    end
    if (cmd.rd_start) fcnt <= '0;
    if (cmd.mac) begin
      acc <= acc + ((user_ok && item_ok) ? ACC_W'(u_rd * v_rd) : '0);
      if (!stat.last_factor) fcnt <= F_W'(fcnt + 1'b1);
    end
    if (cmd.fin_dot) begin
      if (err > ERR_MAX) begin
        su <= 17'sd32767; sat_flag <= 1'b1;
      end else if (err < ERR_MIN) begin
        su <= -17'sd32768; sat_flag <= 1'b1;
      end else begin
        su <= 17'(err);
      end
    end
    if (cmd.upd_mul) begin
      gu_r <= gu_c;
      gv_r <= gv_c;
    end
    if (cmd.upd_wr) begin
      if (nu > NEW_MAX || nu < NEW_MIN || nv > NEW_MAX || nv < NEW_MIN)
        sat_flag <= 1'b1;
      if (!stat.last_factor) fcnt <= F_W'(fcnt + 1'b1);
    end
  end

  assign pu = 57'(signed'({1'b0, learn_rate})) * 57'(gu_r);
  assign pv = 57'(signed'({1'b0, learn_rate})) * 57'(gv_r);

  always_comb begin
    nu    = 26'(u_rd) + 26'(pu >>> 32);
    nv    = 26'(v_rd) + 26'(pv >>> 32);
    u_new = (nu > NEW_MAX) ? 16'sh7fff : (nu < NEW_MIN) ? 16'sh8000 : nu[15:0];
    v_new = (nv > NEW_MAX) ? 16'sh7fff : (nv < NEW_MIN) ? 16'sh8000 : nv[15:0];
  end

  // result
  assign mn = (ACC_W-15)'(signed'({1'b0, min_rating}));
  assign mx = (ACC_W-15)'(signed'({1'b0, max_rating}));
  always_comb begin
    cl = (ACC_W-15)'(pred);
    if (cl < mn) cl = mn;
    if (cl > mx) cl = mx;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_set) begin
      if (cmd.capture) begin
        result_value <= '0;
        clamped      <= 1'b0;
      end else if (cmd_r == CMD_PREDICT) begin
        result_value <= cl[15:0];
        clamped      <= (cl != (ACC_W-15)'(pred));
      end else if (cmd.fin_dot) begin
        result_value <= (err > ERR_MAX) ? 16'sh7fff :
                        (err < ERR_MIN) ? 16'sh8000 : err[15:0];
        clamped      <= (err > ERR_MAX) || (err < ERR_MIN);
      end else begin
        result_value <= su[15:0];
        clamped      <= sat_flag || nu > NEW_MAX || nu < NEW_MIN
                        || nv > NEW_MAX || nv < NEW_MIN;
      end
    end
  end

  a_fcnt_range: assert property (@(posedge clk)
    (cmd.mac || cmd.upd_wr) |-> (32'(fcnt) < FACTORS)) else $error("factor count");
  a_upd_rows: assert property (@(posedge clk)
    cmd.upd_mul |-> stat.rows_ok) else $error("update on invalid rows");
  a_no_overlap: assert property (@(posedge clk)
    !(cmd.load_wr && cmd.upd_wr)) else $error("write overlap");

endmodule

[hdl/matrix_factorization_sgd_core.sv]
`timescale 1ns / 1ps
// Flow: one item at a time; the next is accepted only once the controller is
// idle again and no held result is stalled at the output. This is set by one
// factor-memory port per table, walked one factor per cycle for the dot
// product and by read, multiply and write steps per factor for the update.
// Reset: synchronous, restores register defaults and idles the controller;
// factor tables are not cleared and hold garbage until loaded.
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_core
// Funk SVD trainer and predictor with APB register port.
// ----------------------------------------------------------------------------
module matrix_factorization_sgd_core
  import mfsgd_pkg::*;
#(
  parameter int NUM_USERS = NUM_USERS_DEF,
  parameter int NUM_ITEMS = NUM_ITEMS_DEF,
  parameter int FACTORS   = FACTORS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              command,
  input  logic [IDX_W-1:0]        user,
  input  logic [IDX_W-1:0]        item,
  input  logic [RAT_W-1:0]        rating,
  input  logic                    load_table,
  input  logic [FIDX_W-1:0]       factor_index,
  input  logic signed [VAL_W-1:0] load_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] result_value,
  output logic                    clamped
);

  logic [15:0]      learn_rate, regularization;
  logic [RAT_W-1:0] min_rating, max_rating;
  mfsgd_cmd_t       cmd;
  mfsgd_stat_t      stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate     <= 16'd524;
      regularization <= 16'd4915;
      min_rating     <= 11'd128;
      max_rating     <= 11'd1280;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_LEARN_RATE: learn_rate     <= pwdata[15:0];
        REG_REGULARIZE: regularization <= pwdata[15:0];
        REG_MIN_RATING: min_rating     <= pwdata[RAT_W-1:0];
        REG_MAX_RATING: max_rating     <= pwdata[RAT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LEARN_RATE: prdata = {16'd0, learn_rate};
      REG_REGULARIZE: prdata = {16'd0, regularization};
      REG_MIN_RATING: prdata = {21'd0, min_rating};
      REG_MAX_RATING: prdata = {21'd0, max_rating};
    endcase
  end

  mfsgd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .command, .out_valid, .out_stall,
    .stat, .cmd
  );

  mfsgd_datapath #(
    .NUM_USERS(NUM_USERS), .NUM_ITEMS(NUM_ITEMS), .FACTORS(FACTORS)
  ) u_dp (
    .clk, .cmd, .stat, .command, .user, .item, .rating, .load_table,
    .factor_index, .load_value, .learn_rate, .regularization,
    .min_rating, .max_rating, .result_value, .clamped
  );

endmodule

[verif/tb_matrix_factorization_sgd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_factorization_sgd_core
// Self-checking bench for the fixed-point Funk SVD core. Factor rows are
// preloaded, then a directed table and a long random mix of load, train,
// predict and unused commands run under several register settings. Every
// result transfer is checked against a directed row's expected value or an in-bench model of the factor tables.
// Train and predict only touch rows whose factors have all been loaded.
// ----------------------------------------------------------------------------
module tb_matrix_factorization_sgd_core;
  import mfsgd_pkg::*;

  localparam int NU = NUM_USERS_DEF;
  localparam int NI = NUM_ITEMS_DEF;
  localparam int NF = FACTORS_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 4 * NF + 10;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        usr;
    logic [IDX_W-1:0]        itm;
    logic [RAT_W-1:0]        rat;
    logic                    tbl;
    logic [FIDX_W-1:0]       fidx;
    logic signed [VAL_W-1:0] val;
  } mf_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] rv;
    logic                    cl;
  } mf_res_t;

  typedef struct {
    mf_req_t                 req;
    bit                      known;
    logic signed [VAL_W-1:0] rv;
    logic                    cl;
  } dir_row_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] command;
  logic [IDX_W-1:0] user, item;
  logic [RAT_W-1:0] rating;
  logic load_table;
  logic [FIDX_W-1:0] factor_index;
  logic signed [VAL_W-1:0] load_value, result_value;
  logic clamped;

  matrix_factorization_sgd_core dut (.*);

  shortint user_rows [NU*NF];
  shortint item_rows [NI*NF];
  bit [NF-1:0] user_loaded [NU];
  bit [NF-1:0] item_loaded [NI];
  int ready_users[$], ready_items[$];
  bit [15:0] lr_q16, reg_q16;
  bit [10:0] rmin, rmax;
  mf_res_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 13;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint sat16(longint x, inout bit flag);
    if (x > 32767) begin
      flag = 1;
      return 32767;
    end
    if (x < -32768) begin
      flag = 1;
      return -32768;
    end
    return x;
  endfunction

  function automatic longint row_dot(int u, int i);
    longint acc;
    acc = 0;
    for (int f = 0; f < NF; f++)
      acc += longint'(user_rows[u*NF+f]) * longint'(item_rows[i*NF+f]);
    return acc >>> 16;
  endfunction

  function automatic mf_res_t sgd_step(mf_req_t r);
    mf_res_t res;
    bit flag;
    longint p, c, err, u, v, gu, gv, lr, rg;
    int ui, ii;
    flag = 0;
    res.rv = 0;
    ui = r.usr;
    ii = r.itm;
    lr = lr_q16;
    rg = reg_q16;
    case (r.cmd)
      CMD_LOAD: begin
        if (r.fidx < NF) begin
          if (!r.tbl) begin
            user_rows[ui*NF+r.fidx] = r.val;
            user_loaded[ui][r.fidx] = 1;
            if (&user_loaded[ui] && !(ui inside {ready_users}))
              ready_users = {ready_users, ui};
          end else begin
            item_rows[ii*NF+r.fidx] = r.val;
            item_loaded[ii][r.fidx] = 1;
            if (&item_loaded[ii] && !(ii inside {ready_items}))
              ready_items = {ready_items, ii};
          end
        end
      end
      CMD_TRAIN: begin
        err = sat16(longint'(r.rat) - row_dot(ui, ii), flag);
        res.rv = VAL_W'(err);
        for (int f = 0; f < NF; f++) begin
          u = user_rows[ui*NF+f];
          v = item_rows[ii*NF+f];
          gu = err * v * 256 - rg * u;
          gv = err * u * 256 - rg * v;
          user_rows[ui*NF+f] = shortint'(sat16(u + ((lr * gu) >>> 32), flag));
          item_rows[ii*NF+f] = shortint'(sat16(v + ((lr * gv) >>> 32), flag));
        end
      end
      CMD_PREDICT: begin
        p = row_dot(ui, ii);
        c = p;
        if (c < longint'(rmin)) c = rmin;
        if (c > longint'(rmax)) c = rmax;
        flag = (c != p);
        res.rv = VAL_W'(c);
      end
      default: ;
    endcase
    res.cl = flag;
    return res;
  endfunction

  function automatic mf_req_t mk_req(logic [1:0] cmd, int u, int i, int rat, bit tbl,
                                     int fidx, int val);
    mf_req_t r;
    r.cmd = cmd;
    r.usr = IDX_W'(u);
    r.itm = IDX_W'(i);
    r.rat = RAT_W'(rat);
    r.tbl = tbl;
    r.fidx = FIDX_W'(fidx);
    r.val = VAL_W'(val);
    return r;
  endfunction

  function automatic dir_row_t mk_row(mf_req_t r, bit known, int rv, bit cl);
    dir_row_t d;
    d.req = r;
    d.known = known;
    d.rv = VAL_W'(rv);
    d.cl = cl;
    return d;
  endfunction

  function automatic int rand_factor();
    if ($urandom_range(99) < 70) return int'($urandom_range(8191)) - 4096;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic send(mf_req_t r, bit known = 0, mf_res_t typed = '{0, 0});
    mf_res_t res;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1;
    command <= r.cmd;
    user <= r.usr;
    item <= r.itm;
    rating <= r.rat;
    load_table <= r.tbl;
    factor_index <= r.fidx;
    load_value <= r.val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = sgd_step(r);
    pending_results = {pending_results, known ? typed : res};
  endtask

  task automatic load_row(bit tbl, int row, int val, bit rnd);
    for (int f = 0; f < NF; f++)
      send(mk_req(CMD_LOAD, tbl ? $urandom_range(1023) : row,
                  tbl ? row : $urandom_range(1023), $urandom_range(1280), tbl, f,
                  rnd ? rand_factor() : val));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, int val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    case (idx)
      REG_LEARN_RATE: lr_q16 = 16'(val);
      REG_REGULARIZE: reg_q16 = 16'(val);
      REG_MIN_RATING: rmin = 11'(val);
      default:        rmax = 11'(val);
    endcase
  endtask

  task automatic set_regs(int lr, int rg, int mn, int mx);
    drain();
    reg_write(REG_LEARN_RATE, lr);
    reg_write(REG_REGULARIZE, rg);
    reg_write(REG_MIN_RATING, mn);
    reg_write(REG_MAX_RATING, mx);
  endtask

  task automatic random_items(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      idle_pct = (n >= count / 3 && n < count / 2) ? 0 : 13;
      pick = $urandom_range(99);
      if (pick < 40)
        send(mk_req(CMD_TRAIN, ready_users[$urandom_range(ready_users.size()-1)],
                    ready_items[$urandom_range(ready_items.size()-1)],
                    $urandom_range(1280), $urandom_range(1), $urandom_range(15),
                    $urandom_range(65535)));
      else if (pick < 70)
        send(mk_req(CMD_PREDICT, ready_users[$urandom_range(ready_users.size()-1)],
                    ready_items[$urandom_range(ready_items.size()-1)],
                    $urandom_range(1280), $urandom_range(1), $urandom_range(15),
                    $urandom_range(65535)));
      else if (pick < 90)
        send(mk_req(CMD_LOAD, $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1280), $urandom_range(1),
                    ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(9),
                    rand_factor()));
      else if (pick < 93) begin
        load_row($urandom_range(1), $urandom_range(1023), 0, 1);
        n += NF - 1;
      end else
        send(mk_req(CMD_UNUSED, $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1280), $urandom_range(1), $urandom_range(15),
                    $urandom_range(65535)));
    end
  endtask

  always @(posedge clk) begin
    mf_res_t want;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing pending: result_value %0d", result_value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (result_value !== want.rv) begin
            $error("result_value: expected %0d, got %0d", want.rv, result_value);
            errors++;
          end
          if (clamped !== want.cl) begin
            $error("clamped: expected %0d, got %0d", want.cl, clamped);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_valid = 0;
    command = CMD_LOAD;
    user = 0;
    item = 0;
    rating = 0;
    load_table = 0;
    factor_index = 0;
    load_value = 0;
    lr_q16 = 524;
    reg_q16 = 4915;
    rmin = 128;
    rmax = 1280;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    load_row(0, 0, 0, 0);
    load_row(1, 0, 0, 0);
    load_row(0, 1023, 32767, 0);
    load_row(1, 1023, -32768, 0);
    load_row(0, 341, 0, 1);
    load_row(1, 341, 0, 1);
    load_row(0, 682, 0, 1);
    load_row(1, 682, 0, 1);

    dir_rows = {dir_rows, mk_row(mk_req(CMD_PREDICT, 0, 0, 0, 0, 0, 0), 1, 128, 1)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_PREDICT, 1023, 1023, 0, 0, 0, 0), 1, 128, 1)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_PREDICT, 0, 1023, 0, 0, 0, 0), 1, 128, 1)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_UNUSED, 1023, 1023, 1280, 1, 15, -1), 1, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_LOAD, 5, 5, 0, 0, 15, 32767), 1, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_LOAD, 5, 5, 0, 1, 12, -32768), 1, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_TRAIN, 0, 0, 1280, 0, 0, 0), 1, 1280, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_TRAIN, 0, 0, 0, 0, 0, 0), 1, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_TRAIN, 1023, 1023, 0, 0, 0, 0), 1, 32767, 1)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_PREDICT, 1023, 1023, 0, 0, 0, 0), 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_TRAIN, 341, 341, 700, 0, 0, 0), 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_PREDICT, 341, 682, 0, 0, 0, 0), 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_LOAD, 341, 0, 0, 0, 0, -32768), 1, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_LOAD, 0, 682, 0, 1, 9, 32767), 1, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_PREDICT, 341, 341, 0, 0, 0, 0), 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_TRAIN, 682, 1023, 1024, 0, 0, 0), 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_UNUSED, 0, 0, 0, 0, 0, 0), 1, 0, 0)};
    dir_rows = {dir_rows, mk_row(mk_req(CMD_PREDICT, 1023, 0, 0, 0, 0, 0), 1, 128, 1)};
    foreach (dir_rows[k])
      send(dir_rows[k].req, dir_rows[k].known, '{dir_rows[k].rv, dir_rows[k].cl});

    random_items(190);
    set_regs(65535, 65535, 0, 1280);
    random_items(190);
    set_regs(0, 0, 1280, 0);
    random_items(190);
    set_regs(2000, 100, 200, 1000);
    random_items(190);
    set_regs(1, 0, 1280, 1280);
    random_items(190);

    drain();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
